### rtl/core/pucc_pkg.sv
// Shared types, codes and helpers for the pixel unpack and cursor composite block.
// Used by every module in rtl/core; depends on nothing else.
package pucc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PIXEL_FORMAT      = 3'd0;
    localparam logic [2:0] CFG_SWAP_MODE         = 3'd1;
    localparam logic [2:0] CFG_CURSOR_TYPE       = 3'd2;
    localparam logic [2:0] CFG_CURSOR_BACKGROUND = 3'd3;
    localparam logic [2:0] CFG_CURSOR_FOREGROUND = 3'd4;

    // Framebuffer formats.
    localparam logic [2:0] FMT_RGB565 = 3'd3;
    localparam logic [2:0] FMT_RGB888 = 3'd4;
    localparam logic [2:0] FMT_RESET  = FMT_RGB888;

    // Byte order modes.
    localparam logic [1:0] SWAP_HALVES = 2'd1;
    localparam logic [1:0] SWAP_FULL   = 2'd3;

    // Cursor kinds.
    localparam logic [1:0] CUR_MASKED = 2'd1;
    localparam logic [1:0] CUR_ARGB   = 2'd2;

    // Masked cursor codes.
    localparam logic [1:0] CODE_BG     = 2'd0;
    localparam logic [1:0] CODE_FG     = 2'd1;
    localparam logic [1:0] CODE_KEEP   = 2'd2;
    localparam logic [1:0] CODE_INVERT = 2'd3;

    localparam int unsigned NUM_CHAN = 3;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_BG,
        ACT_FG,
        ACT_KEEP,
        ACT_INVERT,
        ACT_BLEND
    } t_action;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic [1:0]  swap_mode;
        logic [1:0]  cursor_type;
        logic [31:0] cursor_background;
        logic [31:0] cursor_foreground;
    } t_cfg;

    // After unpack: current pixel, action and the byte-corrected cursor word.
    typedef struct packed {
        logic [31:0] pixel;
        logic        changed;
        t_action     action;
        logic [31:0] argb;
    } t_unp;

    // After the multipliers: per channel alpha*cursor and alpha*pixel.
    typedef struct packed {
        logic [31:0]                 pixel;
        logic                        changed;
        t_action                     action;
        logic [NUM_CHAN-1:0][15:0]   prod_ac;
        logic [NUM_CHAN-1:0][15:0]   prod_ap;
    } t_mul;

    function automatic logic [31:0] order_fix(input logic [31:0] v, input logic [1:0] mode);
        logic [31:0] res;
        unique case (mode)
            SWAP_HALVES: res = {v[23:16], v[31:24], v[7:0], v[15:8]};
            SWAP_FULL:   res = {v[7:0], v[15:8], v[23:16], v[31:24]};
            default:     res = v;
        endcase
        return res;
    endfunction

endpackage

### rtl/core/pucc_unpack.sv
// First pipeline stage: byte order correction, RGB565/RGB888 unpack and cursor decode.
// Depends on pucc_pkg.
module pucc_unpack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pucc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_fb_word,
    input  logic [31:0]       i_previous_pixel,
    input  logic              i_under_cursor,
    input  logic [1:0]        i_cursor_code,
    input  logic [31:0]       i_cursor_argb,
    output logic              o_valid,
    input  logic              i_ready,
    output pucc_pkg::t_unp    o_data
);

    logic           r_valid;
    pucc_pkg::t_unp r_data;
    pucc_pkg::t_unp n_data;

    always_comb begin
        logic [31:0] fix16;
        logic [31:0] fix32;
        logic [15:0] w;
        fix16 = pucc_pkg::order_fix({16'h0000, i_fb_word[15:0]}, i_cfg.swap_mode);
        fix32 = pucc_pkg::order_fix(i_fb_word, i_cfg.swap_mode);
        w     = fix16[15:0];

        n_data.argb = pucc_pkg::order_fix(i_cursor_argb, i_cfg.swap_mode);

        priority if (i_cfg.pixel_format == pucc_pkg::FMT_RGB565) begin
            n_data.pixel   = {8'h00, w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
            n_data.changed = 1'b1;
        end else if (i_cfg.pixel_format == pucc_pkg::FMT_RGB888) begin
            n_data.pixel   = {8'h00, fix32[23:0]};
            n_data.changed = 1'b1;
        end else begin
            n_data.pixel   = i_previous_pixel;
            n_data.changed = 1'b0;
        end

        n_data.action = pucc_pkg::ACT_NONE;
        if (i_under_cursor) begin
            unique case (i_cfg.cursor_type)
                pucc_pkg::CUR_MASKED: begin
                    unique case (i_cursor_code)
                        pucc_pkg::CODE_BG:     n_data.action = pucc_pkg::ACT_BG;
                        pucc_pkg::CODE_FG:     n_data.action = pucc_pkg::ACT_FG;
                        pucc_pkg::CODE_KEEP:   n_data.action = pucc_pkg::ACT_KEEP;
                        pucc_pkg::CODE_INVERT: n_data.action = pucc_pkg::ACT_INVERT;
                        default:               n_data.action = pucc_pkg::ACT_NONE;
                    endcase
                end
                pucc_pkg::CUR_ARGB: n_data.action = pucc_pkg::ACT_BLEND;
                default:            n_data.action = pucc_pkg::ACT_NONE;
            endcase
        end
        if (n_data.action != pucc_pkg::ACT_NONE) begin
            n_data.changed = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/pucc_blend_mul.sv
// Second pipeline stage: per-channel alpha products for the ARGB cursor blend.
// Depends on pucc_pkg.
module pucc_blend_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pucc_pkg::t_unp    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pucc_pkg::t_mul    o_data
);

    logic           r_valid;
    pucc_pkg::t_mul r_data;
    pucc_pkg::t_mul n_data;

    always_comb begin
        logic [7:0] alpha;
        alpha          = i_data.argb[31:24];
        n_data.pixel   = i_data.pixel;
        n_data.changed = i_data.changed;
        n_data.action  = i_data.action;
        for (int i = 0; i < pucc_pkg::NUM_CHAN; i++) begin
            n_data.prod_ac[i] = alpha * i_data.argb[8*i +: 8];
            n_data.prod_ap[i] = alpha * i_data.pixel[8*i +: 8];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/pucc_compose.sv
// Third pipeline stage and output register: blend sum and final cursor selection.
// Depends on pucc_pkg.
module pucc_compose (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_cursor_background,
    input  logic [31:0]       i_cursor_foreground,
    input  logic              i_valid,
    output logic              o_ready,
    input  pucc_pkg::t_mul    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_pixel,
    output logic              o_changed
);

    logic        r_valid;
    logic [31:0] r_pixel;
    logic        r_changed;
    logic [31:0] n_pixel;

    always_comb begin
        logic [16:0] sum;
        logic [23:0] blended;
        blended = '0;
        for (int i = 0; i < pucc_pkg::NUM_CHAN; i++) begin
            // 256*p + a*c never falls below a*p, so the sum cannot wrap.
            sum = {1'b0, i_data.pixel[8*i +: 8], 8'h00} + {1'b0, i_data.prod_ac[i]}
                - {1'b0, i_data.prod_ap[i]};
            blended[8*i +: 8] = sum[15:8];
        end
        unique case (i_data.action)
            pucc_pkg::ACT_BG:     n_pixel = i_cursor_background;
            pucc_pkg::ACT_FG:     n_pixel = i_cursor_foreground;
            pucc_pkg::ACT_INVERT: n_pixel = {i_data.pixel[31:24], ~i_data.pixel[23:0]};
            pucc_pkg::ACT_BLEND:  n_pixel = {8'h00, blended};
            default:              n_pixel = i_data.pixel;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel   <= n_pixel;
            r_changed <= i_data.changed;
        end
    end

    assign o_valid   = r_valid;
    assign o_pixel   = r_pixel;
    assign o_changed = r_changed;

    // A blended result always has a clear top byte.
    a_blend_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_data.action == pucc_pkg::ACT_BLEND)
        |=> (r_pixel[31:24] == 8'h00 && r_changed))
        else $error("blended pixel has nonzero top byte");

    // Any cursor action marks the pixel as changed.
    a_action_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_data.action != pucc_pkg::ACT_NONE) |-> i_data.changed)
        else $error("cursor action without changed flag");

    // A loaded beat is held until the downstream side takes it.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> r_valid)
        else $error("accepted beat lost in output stage");

endmodule

### rtl/core/pixel_unpack_cursor_composite.sv
// Top level of the pixel unpack and cursor composite block: configuration registers
// and the three-stage pipeline. Depends on pucc_pkg, pucc_unpack, pucc_blend_mul
// and pucc_compose.
//
// Usage: one beat on the slave stream is one screen pixel. The raw framebuffer word
// is byte-order corrected, unpacked from RGB565 or RGB888 (any other format keeps
// the pixel on screen), and the cursor is applied: a two-bit masked cursor or an
// ARGB alpha blend. Each input beat gives exactly one output beat on the master
// stream carrying the displayed pixel and a changed flag in tuser.
// Each beat passes through unpack, the alpha multipliers, then the blend sum and
// final select in the output register. Throughput is one pixel per cycle while
// the receiver keeps taking output beats on the master stream.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor takes its beat, so bubbles close up. When the receiver stalls, the
// output register holds its beat and the stages fill; input ready drops only
// once all three are occupied. Nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: RGB888, no byte swap, cursor off, background and foreground zero.
// Configuration writes are taken every cycle and are meant for an idle pipeline.
module pixel_unpack_cursor_composite (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Pixel input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [31:0] fb_word, [63:32] previous_pixel, [95:64] cursor_argb
    input  logic [2:0]  s_tuser,   // [0] under_cursor, [2:1] cursor_code
    // Pixel output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pixel
    output logic        m_tuser    // [0] changed
);

    pucc_pkg::t_cfg r_cfg;
    pucc_pkg::t_unp unp_data;
    pucc_pkg::t_mul mul_data;
    logic           unp_valid;
    logic           mul_valid;
    logic           mul_ready;
    logic           cmp_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format      <= pucc_pkg::FMT_RESET;
            r_cfg.swap_mode         <= 2'd0;
            r_cfg.cursor_type       <= 2'd0;
            r_cfg.cursor_background <= 32'h0;
            r_cfg.cursor_foreground <= 32'h0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pucc_pkg::CFG_PIXEL_FORMAT:      r_cfg.pixel_format      <= i_cfg_data[2:0];
                pucc_pkg::CFG_SWAP_MODE:         r_cfg.swap_mode         <= i_cfg_data[1:0];
                pucc_pkg::CFG_CURSOR_TYPE:       r_cfg.cursor_type       <= i_cfg_data[1:0];
                pucc_pkg::CFG_CURSOR_BACKGROUND: r_cfg.cursor_background <= i_cfg_data;
                pucc_pkg::CFG_CURSOR_FOREGROUND: r_cfg.cursor_foreground <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pucc_unpack u_unpack (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (s_tvalid),
        .o_ready          (s_tready),
        .i_fb_word        (s_tdata[31:0]),
        .i_previous_pixel (s_tdata[63:32]),
        .i_under_cursor   (s_tuser[0]),
        .i_cursor_code    (s_tuser[2:1]),
        .i_cursor_argb    (s_tdata[95:64]),
        .o_valid          (unp_valid),
        .i_ready          (mul_ready),
        .o_data           (unp_data)
    );

    pucc_blend_mul u_blend_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (unp_valid),
        .o_ready (mul_ready),
        .i_data  (unp_data),
        .o_valid (mul_valid),
        .i_ready (cmp_ready),
        .o_data  (mul_data)
    );

    pucc_compose u_compose (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cursor_background (r_cfg.cursor_background),
        .i_cursor_foreground (r_cfg.cursor_foreground),
        .i_valid             (mul_valid),
        .o_ready             (cmp_ready),
        .i_data              (mul_data),
        .o_valid             (m_tvalid),
        .i_ready             (m_tready),
        .o_pixel             (m_tdata),
        .o_changed           (m_tuser)
    );

    // With all three stages full and the receiver stalled, no new beat may enter.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (unp_valid && mul_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline full and stalled");

    // An empty first stage always takes a beat.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !unp_valid |-> s_tready)
        else $error("first stage empty but input not ready");

    // An accepted input beat lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> unp_valid)
        else $error("accepted beat not held in first stage");

    // A format write takes effect on the next cycle.
    a_cfg_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == pucc_pkg::CFG_PIXEL_FORMAT)
        |=> (r_cfg.pixel_format == $past(i_cfg_data[2:0])))
        else $error("pixel format register not updated");

endmodule
